[hdl/ckl_pkg.sv]
// ----------------------------------------------------------------------------
// ckl_pkg: circular key list shared definitions
// Sizes, operation and status codes, and the request and response structs.
// ----------------------------------------------------------------------------
package ckl_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [5:0] position;
    logic [6:0] entry_count;
  } rsp_t;

endpackage

[hdl/circular_key_list.sv]
// ----------------------------------------------------------------------------
// circular_key_list: ordered list of signed 32-bit keys
// Insert at tail, search for first match, remove first match keeping order.
//
// Requests enter on req/req_valid/req_stall, one response per request leaves
// on rsp/rsp_valid/rsp_stall. A transfer happens when valid is high and stall
// is low. req_stall is high while a request is being worked on; one request
// is handled at a time.
// Insert and unknown codes go straight to the done state. Search walks the key
// memory one read per cycle. Remove adds a shift of the later keys, one read
// and one write per cycle.
// The single read port of the key memory sets this pace.
// The response sits in an output register; a new request is taken while it
// waits, but its own response is held back until the register is freed.
// Reset (rst, synchronous) empties the list; the key memory is not cleared.
// ----------------------------------------------------------------------------
module circular_key_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ckl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ckl_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                            state;
  logic [ckl_pkg::CNT_W-1:0]         count;
  logic [1:0]                        op;
  logic signed [ckl_pkg::KEY_W-1:0]  key;
  logic [1:0]                        status;
  logic                              hit;
  logic [ckl_pkg::ADDR_W-1:0]        pos;
  logic [ckl_pkg::CNT_W-1:0]         issue_idx;
  logic                              pend;
  logic [ckl_pkg::ADDR_W-1:0]        pend_idx;

  logic                              ram_we;
  logic [ckl_pkg::ADDR_W-1:0]        ram_waddr;
  logic [ckl_pkg::KEY_W-1:0]         ram_wdata;
  logic [ckl_pkg::KEY_W-1:0]         ram_rdata;

  logic                              accept;
  logic                              full;
  logic                              out_free;
  logic                              issue_ok;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign full      = (count >= ckl_pkg::CNT_W'(ckl_pkg::CAPACITY));
  assign out_free  = !rsp_valid || !rsp_stall;
  assign issue_ok  = (issue_idx < count);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = ram_rdata;
    case (state)
      S_IDLE: begin
        ram_we    = accept && (req.func == ckl_pkg::OP_INSERT) && !full;
        ram_waddr = count[ckl_pkg::ADDR_W-1:0];
        ram_wdata = req.key;
      end
      S_SHIFT: begin
        ram_we = pend;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ckl_ram #(
    .DEPTH (ckl_pkg::CAPACITY),
    .WIDTH (ckl_pkg::KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx[ckl_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= req.func;
            key       <= req.key;
            status    <= (req.func == ckl_pkg::OP_INSERT && full) ?
                         ckl_pkg::ST_FULL : ckl_pkg::ST_OK;
            hit       <= 1'b0;
            pos       <= '0;
            issue_idx <= '0;
            pend      <= 1'b0;
            if (req.func == ckl_pkg::OP_INSERT) begin
              if (!full) begin
                count <= count + 1'b1;
              end
              state <= S_DONE;
            end else if (req.func == ckl_pkg::OP_SEARCH ||
                         req.func == ckl_pkg::OP_REMOVE) begin
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (pend && (ram_rdata == key)) begin
            hit <= 1'b1;
            pos <= pend_idx;
            if (op == ckl_pkg::OP_REMOVE) begin
              issue_idx <= ckl_pkg::CNT_W'(pend_idx) + 1'b1;
              pend      <= 1'b0;
              state     <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end else if (issue_ok) begin
            pend      <= 1'b1;
            pend_idx  <= issue_idx[ckl_pkg::ADDR_W-1:0];
            issue_idx <= issue_idx + 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            status <= ckl_pkg::ST_MISSING;
            state  <= S_DONE;
          end
        end
        S_SHIFT: begin
          // read at issue_idx, write one place lower on the next cycle
          if (issue_ok) begin
            pend      <= 1'b1;
            pend_idx  <= ckl_pkg::ADDR_W'(issue_idx - 1'b1);
            issue_idx <= issue_idx + 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count - 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= status;
            rsp.found       <= hit;
            rsp.position    <= 6'(pos);
            rsp.entry_count <= 7'(count);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ckl_pkg::CNT_W'(ckl_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(count) |->
      (count == $past(count) + 1'b1) || (count == $past(count) - 1'b1))
    else $error("entry count moved by more than one");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && pend |-> ckl_pkg::CNT_W'(pend_idx) < count)
    else $error("compare outside held entries");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && (rsp.status == ckl_pkg::ST_FULL) |->
      count == ckl_pkg::CNT_W'(ckl_pkg::CAPACITY))
    else $error("full reported while space is left");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == ckl_pkg::ST_OK)
    else $error("match reported with error status");

endmodule

[hdl/ckl_ram.sv]
// ----------------------------------------------------------------------------
// ckl_ram: simple dual-port key memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ckl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: circular key list testbench
// Drives insert, search, remove and unused-code requests through the
// valid/stall request channel and checks each response, field by field,
// against the directed table's expected values or a queue-based list model
// kept in the testbench. A short table of directed requests comes first, then
// random phases that fill the list past full, mix operations, drain it, and
// hold the response side off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    bit          typed;
    logic [1:0]  e_status;
    logic        e_found;
    logic [5:0]  e_position;
    logic [6:0]  e_count;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  ckl_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ckl_pkg::rsp_t rsp;

  logic [31:0]   held_keys[$];
  ckl_pkg::rsp_t pending_rsps[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  int            n_requests = 0;
  int            n_responses = 0;
  int            n_hits = 0;
  int            n_missing = 0;
  int            n_full = 0;
  int            peak_count = 0;
  bit            calm = 1'b0;
  bit            hold_off_go = 1'b0;

  // after 7: [min, max, 0, -1]; rows with typed clear are left to the list model
  dir_row_t dir_tab [22] = '{
    '{ckl_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, ckl_pkg::ST_MISSING, 1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, ckl_pkg::ST_MISSING, 1'b0, 6'd0, 7'd0},
    '{OP_UNUSED,          32'h0000_0005, 1'b1, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_INSERT, 32'h8000_0000, 1'b1, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd1},
    '{ckl_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd2},
    '{ckl_pkg::OP_INSERT, 32'h0000_0000, 1'b1, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd3},
    '{ckl_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd4},
    '{ckl_pkg::OP_SEARCH, 32'h8000_0000, 1'b1, ckl_pkg::ST_OK,      1'b1, 6'd0, 7'd4},
    '{ckl_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1, ckl_pkg::ST_OK,      1'b1, 6'd3, 7'd4},
    '{ckl_pkg::OP_SEARCH, 32'h1234_5678, 1'b1, ckl_pkg::ST_MISSING, 1'b0, 6'd0, 7'd4},
    '{ckl_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'h8000_0000, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{OP_UNUSED,          32'hAAAA_AAAA, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'h5555_5555, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_SEARCH, 32'h0000_0000, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'h0000_0000, 1'b0, ckl_pkg::ST_OK,      1'b0, 6'd0, 7'd0},
    '{ckl_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, ckl_pkg::ST_MISSING, 1'b0, 6'd0, 7'd0}
  };

  circular_key_list DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic ckl_pkg::rsp_t apply_list_op(ckl_pkg::req_t r);
    ckl_pkg::rsp_t o;
    int            idx;
    o = '0;
    idx = -1;
    case (r.func)
      ckl_pkg::OP_INSERT: begin
        if (held_keys.size() >= ckl_pkg::CAPACITY) o.status = ckl_pkg::ST_FULL;
        else held_keys.push_back(r.key);
      end
      ckl_pkg::OP_SEARCH, ckl_pkg::OP_REMOVE: begin
        for (int i = 0; i < held_keys.size(); i++)
          if (idx < 0 && held_keys[i] == r.key) idx = i;
        if (idx < 0) begin
          o.status = ckl_pkg::ST_MISSING;
        end else begin
          o.found = 1'b1;
          o.position = 6'(idx);
          if (r.func == ckl_pkg::OP_REMOVE) held_keys.delete(idx);
        end
      end
      default: ;
    endcase
    o.entry_count = 7'(held_keys.size());
    if (held_keys.size() > peak_count) peak_count = held_keys.size();
    return o;
  endfunction

  task automatic send_req(input ckl_pkg::req_t r, input bit typed,
                          input ckl_pkg::rsp_t typed_rsp);
    ckl_pkg::rsp_t model_rsp;
    while (!calm && $urandom_range(99) < 22) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    model_rsp = apply_list_op(r);
    pending_rsps.push_back(typed ? typed_rsp : model_rsp);
    n_requests++;
  endtask

  task automatic take_rsp();
    ckl_pkg::rsp_t want;
    if (rsp_valid && !rsp_stall) begin
      n_responses++;
      if (pending_rsps.size() == 0) begin
        $error("response with none expected: %p", rsp);
        mismatches++;
      end else begin
        want = pending_rsps.pop_front();
        if (rsp.status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.found != want.found) begin
          $error("found: expected %0d, actual %0d", want.found, rsp.found);
          mismatches++;
        end
        if (rsp.position != want.position) begin
          $error("position: expected %0d, actual %0d", want.position, rsp.position);
          mismatches++;
        end
        if (rsp.entry_count != want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 want.entry_count, rsp.entry_count);
          mismatches++;
        end
        if (want.found) n_hits++;
        if (want.status == ckl_pkg::ST_MISSING) n_missing++;
        if (want.status == ckl_pkg::ST_FULL) n_full++;
      end
    end
  endtask

  initial begin
    wait (rst == 1'b0);
    forever begin
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          rsp_stall <= 1'b1;
          @(posedge clk);
          take_rsp();
        end
      end
      rsp_stall <= (!calm && $urandom_range(99) < 22);
      @(posedge clk);
      take_rsp();
    end
  end

  function automatic logic [31:0] pick_key(bit from_list);
    if (from_list && held_keys.size() > 0) begin
      if ($urandom_range(3) == 0) return held_keys[held_keys.size()-1];
      return held_keys[$urandom_range(held_keys.size()-1)];
    end
    if ($urandom_range(1) == 0) return $urandom;
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      5: return 32'h5555_5555;
      6: return 32'hAAAA_AAAA;
      default: return 32'h0BAD_F00D;
    endcase
  endfunction

  // weights in percent; whatever is left goes to the unused code
  task automatic run_phase(input int n, input int w_ins, input int w_srch,
                           input int w_rem);
    ckl_pkg::req_t r;
    int            roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < w_ins) r.func = ckl_pkg::OP_INSERT;
      else if (roll < w_ins + w_srch) r.func = ckl_pkg::OP_SEARCH;
      else if (roll < w_ins + w_srch + w_rem) r.func = ckl_pkg::OP_REMOVE;
      else r.func = OP_UNUSED;
      r.key = pick_key(r.func != ckl_pkg::OP_INSERT && $urandom_range(99) < 70);
      send_req(r, 1'b0, '0);
    end
  endtask

  initial begin
    ckl_pkg::req_t r;
    ckl_pkg::rsp_t t;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      r.func = dir_tab[i].func;
      r.key = dir_tab[i].key;
      t.status = dir_tab[i].e_status;
      t.found = dir_tab[i].e_found;
      t.position = dir_tab[i].e_position;
      t.entry_count = dir_tab[i].e_count;
      send_req(r, dir_tab[i].typed, t);
    end

    run_phase(120, 80, 10, 5);
    calm = 1'b1;
    run_phase(200, 34, 33, 30);
    calm = 1'b0;
    run_phase(150, 5, 20, 70);
    hold_off_go = 1'b1;
    run_phase(180, 40, 28, 28);

    req_valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d responses: %0d hits, %0d misses, %0d full rejects",
             n_requests, n_responses, n_hits, n_missing, n_full);
    $display("Largest list size reached: %0d of %0d", peak_count, ckl_pkg::CAPACITY);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
